// ===== hdl/bafe_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the bit array engine.
`timescale 1ns / 1ps
`default_nettype none
package bafe_pkg;

  // Storage geometry
  localparam int WORD_COUNT    = 64;
  localparam int WORD_W        = 64;
  localparam int OFF_W         = 6;
  localparam int IDX_W         = 12;
  localparam int FW_W          = 7;
  localparam int CNT_W         = 13;
  localparam int POP_W         = 7;
  localparam int POS_W         = IDX_W - OFF_W;
  localparam int WORD_AW       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int POSX_W        = (WORD_AW + 1 > POS_W + 1) ? WORD_AW + 1 : POS_W + 1;
  localparam int CAPACITY_BITS = WORD_COUNT * WORD_W;
  localparam int CAP_W         = $clog2(CAPACITY_BITS + 1);
  localparam int CMP_W         = (CAP_W > IDX_W + 1) ? CAP_W : IDX_W + 1;
  localparam int COUNT_MAX     = 8191;

  // Request codes
  localparam logic [2:0] MODE_TEST      = 3'd0;
  localparam logic [2:0] MODE_SET       = 3'd1;
  localparam logic [2:0] MODE_CLEAR     = 3'd2;
  localparam logic [2:0] MODE_FLIP      = 3'd3;
  localparam logic [2:0] MODE_FETCH     = 3'd4;
  localparam logic [2:0] MODE_REPLACE   = 3'd5;
  localparam logic [2:0] MODE_COUNT     = 3'd6;
  localparam logic [2:0] MODE_CLEAR_ALL = 3'd7;

  typedef struct packed {
    logic               rd_req;     // transaction accepted: capture and read both words
    logic               commit;     // write low word, load result
    logic               commit_hi;  // write high word of a spanning replace
    logic               cnt_start;  // clear the count accumulator
    logic               cnt_rd;     // read one word for the count sweep
    logic               cnt_done;   // load count result
    logic [WORD_AW-1:0] cnt_addr;
  } bafe_cmd_t;

  typedef struct packed {
    logic is_count;
    logic need_hi;
  } bafe_sts_t;

endpackage
`default_nettype wire

// ===== hdl/bit_array_field_engine.sv =====
// Top level of the bit array engine: controller and datapath.
//
// A bit array of WORD_COUNT words of 64 bits, all zero after reset.
// Input channel in_valid/in_stall carries one request per transaction:
// in_mode selects test, set, clear, flip, fetch field, replace field,
// count, or clear all. Every request gives exactly one result on the
// out_valid/out_stall channel (read value, bit count, overflow flag).
// Bit, field and clear-all requests read their words on acceptance and
// load the result in state S_MOD; the sequencer then returns to idle
// (through S_WR1 when a replace spans two words, the second word going
// through the single write port). Count walks the store one word a cycle
// through read port 0 in S_CNT, adds the last word in S_CFIN and loads the
// sum in S_CDONE. One request is in work at a time; the next is taken once
// the sequencer is idle, even while the previous result still waits.
// A stalled result holds; the sequencer waits before loading a new one.
// Synchronous reset clears the per-word valid bits at once, so the store
// reads as zero straight away; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module bit_array_field_engine
  import bafe_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [2:0]        in_mode,
  input  wire logic [IDX_W-1:0]  in_bit_index,
  input  wire logic [FW_W-1:0]   in_field_width,
  input  wire logic [WORD_W-1:0] in_write_value,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [WORD_W-1:0]      out_read_value,
  output logic [CNT_W-1:0]       out_bit_count,
  output logic                   out_overflow
);

  bafe_cmd_t cmd;
  bafe_sts_t sts;

  bafe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bafe_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_mode        (in_mode),
    .in_bit_index   (in_bit_index),
    .in_field_width (in_field_width),
    .in_write_value (in_write_value),
    .out_read_value (out_read_value),
    .out_bit_count  (out_bit_count),
    .out_overflow   (out_overflow)
  );

endmodule
`default_nettype wire

// ===== hdl/bafe_ctrl.sv =====
// Sequencing state machine and result handshake for the bit array engine.
`timescale 1ns / 1ps
`default_nettype none
module bafe_ctrl
  import bafe_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire bafe_sts_t sts,
  output bafe_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MOD   = 3'd1;
  localparam logic [2:0] S_WR1   = 3'd2;
  localparam logic [2:0] S_CNT   = 3'd3;
  localparam logic [2:0] S_CFIN  = 3'd4;
  localparam logic [2:0] S_CDONE = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [WORD_AW-1:0] cnt_addr_r, cnt_addr_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_addr_nxt = cnt_addr_r;
    cmd          = '0;
    cmd.cnt_addr = cnt_addr_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.rd_req = 1'b1;
          state_nxt  = S_MOD;
        end
      end
      S_MOD: begin
        if (sts.is_count) begin
          cmd.cnt_start = 1'b1;
          cnt_addr_nxt  = '0;
          state_nxt     = S_CNT;
        end else if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = sts.need_hi ? S_WR1 : S_IDLE;
        end
      end
      S_WR1: begin
        cmd.commit_hi = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_CNT: begin
        cmd.cnt_rd = 1'b1;
        if (cnt_addr_r == WORD_AW'(WORD_COUNT - 1)) begin
          state_nxt = S_CFIN;
        end else begin
          cnt_addr_nxt = cnt_addr_r + 1'b1;
        end
      end
      S_CFIN: begin
        // last word is summed at this edge
        state_nxt = S_CDONE;
      end
      S_CDONE: begin
        if (out_free) begin
          cmd.cnt_done = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit || cmd.cnt_done) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_addr_r  <= cnt_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit || cmd.cnt_done) |-> (!out_valid_r || !out_stall))
    else $error("result loaded while the output slot is occupied");

  a_hi_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit_hi |-> $past(cmd.commit))
    else $error("high word written without a preceding commit");

  a_sweep_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CNT && cnt_addr_r == WORD_AW'(WORD_COUNT - 1)) |=> (state_r == S_CFIN))
    else $error("count sweep overran the last word");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.commit || cmd.cnt_done))
    else $error("result valid without a load");
`endif

endmodule
`default_nettype wire

// ===== hdl/bafe_dpath.sv =====
// Word store, field shifter, popcount accumulator and result registers.
`timescale 1ns / 1ps
`default_nettype none
module bafe_dpath
  import bafe_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bafe_cmd_t          cmd,
  output bafe_sts_t               sts,
  input  wire logic [2:0]         in_mode,
  input  wire logic [IDX_W-1:0]   in_bit_index,
  input  wire logic [FW_W-1:0]    in_field_width,
  input  wire logic [WORD_W-1:0]  in_write_value,
  output logic [WORD_W-1:0]       out_read_value,
  output logic [CNT_W-1:0]        out_bit_count,
  output logic                    out_overflow
);

  logic [WORD_W-1:0]     mem [0:WORD_COUNT-1];
  logic [WORD_COUNT-1:0] valid_r;

  logic [2:0]         mode_r;
  logic [IDX_W-1:0]   idx_r;
  logic [FW_W-1:0]    width_r;
  logic [WORD_W-1:0]  val_r;
  logic [WORD_W-1:0]  rdata0_r, rdata1_r;
  logic               v0_r, v1_r;
  logic               inr0_r, inr1_r;
  logic [WORD_AW-1:0] addr0_r, addr1_r;
  logic               acc_en_r;
  logic [CNT_W-1:0]   acc_r, acc_nxt;
  logic [WORD_W-1:0]  rv_r;
  logic [CNT_W-1:0]   bc_r;
  logic               ovf_r;

  // read address selection
  logic [POSX_W-1:0]  posx0, posx1;
  logic               inr0, inr1;
  logic [WORD_AW-1:0] ra0, ra1;
  logic               rd_en;

  assign posx0 = POSX_W'(in_bit_index[IDX_W-1:OFF_W]);
  assign posx1 = posx0 + 1'b1;
  assign inr0  = posx0 < POSX_W'(WORD_COUNT);
  assign inr1  = posx1 < POSX_W'(WORD_COUNT);
  assign ra0   = cmd.cnt_rd ? cmd.cnt_addr : posx0[WORD_AW-1:0];
  assign ra1   = posx1[WORD_AW-1:0];
  assign rd_en = cmd.rd_req || cmd.cnt_rd;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata0_r <= mem[ra0];
      rdata1_r <= mem[ra1];
      v0_r     <= (cmd.cnt_rd || inr0) && valid_r[ra0];
      v1_r     <= inr1 && valid_r[ra1];
    end
    if (cmd.rd_req) begin
      mode_r  <= in_mode;
      idx_r   <= in_bit_index;
      width_r <= (in_field_width > FW_W'(WORD_W)) ? FW_W'(WORD_W) : in_field_width;
      val_r   <= in_write_value;
      inr0_r  <= inr0;
      inr1_r  <= inr1;
      addr0_r <= ra0;
      addr1_r <= ra1;
    end
  end

  // word arithmetic on the captured transaction
  logic [WORD_W-1:0]   w0, w1, bit_m, mask, vm, new0, new1, rd_val;
  logic [2*WORD_W-1:0] span, m_sh, v_sh;
  logic [OFF_W-1:0]    off;
  logic [CMP_W-1:0]    idx_x, end_x;
  logic                ovf;
  logic                wr0_ok;

  assign off   = idx_r[OFF_W-1:0];
  assign w0    = v0_r ? rdata0_r : '0;
  assign w1    = v1_r ? rdata1_r : '0;
  assign bit_m = WORD_W'(1) << off;
  assign mask  = (width_r == FW_W'(WORD_W)) ? '1 : ((WORD_W'(1) << width_r) - 1'b1);
  assign vm    = val_r & mask;
  assign span  = {w1, w0} >> off;
  assign m_sh  = {{WORD_W{1'b0}}, mask} << off;
  assign v_sh  = {{WORD_W{1'b0}}, vm} << off;
  assign idx_x = CMP_W'(idx_r);
  assign end_x = idx_x + CMP_W'(width_r);
  assign new1  = (w1 & ~m_sh[2*WORD_W-1:WORD_W]) | v_sh[2*WORD_W-1:WORD_W];

  always_comb begin
    rd_val = '0;
    new0   = w0;
    ovf    = 1'b0;
    wr0_ok = 1'b0;
    case (mode_r)
      MODE_TEST: begin
        rd_val = WORD_W'(w0[off]);
        ovf    = idx_x >= CMP_W'(CAPACITY_BITS);
      end
      MODE_SET: begin
        new0   = w0 | bit_m;
        ovf    = idx_x >= CMP_W'(CAPACITY_BITS);
        wr0_ok = 1'b1;
      end
      MODE_CLEAR: begin
        new0   = w0 & ~bit_m;
        ovf    = idx_x >= CMP_W'(CAPACITY_BITS);
        wr0_ok = 1'b1;
      end
      MODE_FLIP: begin
        new0   = w0 ^ bit_m;
        ovf    = idx_x >= CMP_W'(CAPACITY_BITS);
        wr0_ok = 1'b1;
      end
      MODE_FETCH: begin
        rd_val = span[WORD_W-1:0] & mask;
        ovf    = (end_x > CMP_W'(CAPACITY_BITS)) || (idx_x >= CMP_W'(CAPACITY_BITS));
      end
      MODE_REPLACE: begin
        new0   = (w0 & ~m_sh[WORD_W-1:0]) | v_sh[WORD_W-1:0];
        ovf    = (end_x > CMP_W'(CAPACITY_BITS)) || (idx_x >= CMP_W'(CAPACITY_BITS));
        wr0_ok = 1'b1;
      end
      default: begin
        rd_val = '0;
      end
    endcase
  end

  assign sts.is_count = (mode_r == MODE_COUNT);
  assign sts.need_hi  = (mode_r == MODE_REPLACE) && inr1_r &&
                        (m_sh[2*WORD_W-1:WORD_W] != '0);

  // single write port
  logic               wr_en;
  logic [WORD_AW-1:0] wr_addr;
  logic [WORD_W-1:0]  wr_data;
  logic               clr_all;

  assign wr_en   = (cmd.commit && wr0_ok && inr0_r) || cmd.commit_hi;
  assign wr_addr = cmd.commit_hi ? addr1_r : addr0_r;
  assign wr_data = cmd.commit_hi ? new1 : new0;
  assign clr_all = cmd.commit && (mode_r == MODE_CLEAR_ALL);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // an entry never written since reset or clear-all reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n || clr_all) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // popcount sweep, saturating
  logic [POP_W-1:0] pop;
  logic [CNT_W:0]   acc_sum;

  assign pop     = POP_W'($countones(w0));
  assign acc_sum = {1'b0, acc_r} + (CNT_W + 1)'(pop);

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.cnt_start) begin
      acc_nxt = '0;
    end else if (acc_en_r) begin
      acc_nxt = (acc_sum > (CNT_W + 1)'(COUNT_MAX)) ? CNT_W'(COUNT_MAX) : acc_sum[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_en_r <= 1'b0;
    end else begin
      acc_en_r <= cmd.cnt_rd;
    end
    acc_r <= acc_nxt;
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rv_r  <= rd_val;
      bc_r  <= '0;
      ovf_r <= ovf;
    end else if (cmd.cnt_done) begin
      rv_r  <= '0;
      bc_r  <= acc_r;
      ovf_r <= 1'b0;
    end
  end

  assign out_read_value = rv_r;
  assign out_bit_count  = bc_r;
  assign out_overflow   = ovf_r;

endmodule
`default_nettype wire
